// File: hw/rtl/lpp_pkg.sv
// Package for the line position PID: constants, types and register codes.
`timescale 1ns / 1ps
package lpp_pkg;

	localparam int SENSOR_BITS    = 12;
	localparam int GAIN_FRAC_BITS = 32;
	localparam int NUM_SENSORS    = 6;

	localparam int ERR_FRAC  = 8;
	localparam int OUT_FRAC  = 16;
	localparam int ERR_W     = 24;
	localparam int DIFF_W    = ERR_W + 1;
	localparam int MAG_W     = ERR_W + 1;
	localparam int GAIN_W    = 40;
	localparam int GAIN_LO_W = 16;
	localparam int GAIN_HI_W = GAIN_W - GAIN_LO_W;
	localparam int PROD_W    = MAG_W + GAIN_HI_W;
	localparam int FULL_W    = PROD_W + GAIN_LO_W + 1;
	localparam int SCALE_SH  = GAIN_FRAC_BITS + ERR_FRAC - OUT_FRAC;
	localparam int OFFSET_W  = 16;
	localparam int OUT_W     = 32;
	localparam int SUM_W     = OUT_W + 2;

	localparam int WSUM_BITS = (SENSOR_BITS + 10 > ERR_W - 1) ? SENSOR_BITS + 10 : ERR_W - 1;
	localparam int CALC_W    = WSUM_BITS + 3;

	localparam int W_FAR  = 410;
	localparam int W_MID  = 320;
	localparam int W_NEAR = 256;

	localparam int S_TDATA_W = ((NUM_SENSORS * SENSOR_BITS + 7) / 8) * 8;
	localparam int M_TDATA_W = 2 * OUT_W;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = GAIN_W;

	localparam logic [GAIN_W-1:0] GAIN_P_RST = 40'd429496730;
	localparam logic [GAIN_W-1:0] GAIN_I_RST = 40'd17180;
	localparam logic [GAIN_W-1:0] GAIN_D_RST = 40'd34359738368;

	localparam logic signed [ERR_W-1:0] ERR_MAX = {1'b0, {(ERR_W-1){1'b1}}};
	localparam logic signed [ERR_W-1:0] ERR_MIN = {1'b1, {(ERR_W-1){1'b0}}};
	localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

	localparam int STEP_W    = 3;
	localparam logic [STEP_W-1:0] STEP_INTEG = 3'd5;
	localparam logic [STEP_W-1:0] STEP_LAST  = 3'd6;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LINE_OFFSET = 3'd0,
		REG_GAIN_P      = 3'd1,
		REG_GAIN_I_DT   = 3'd2,
		REG_GAIN_D_DT   = 3'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_SUM
	} state_t;

endpackage

// File: hw/rtl/line_position_pid.sv
// Line position PID: weighted sensor error and PID step on one shared multiplier.
// Each accepted input beat runs through the error register, 7 multiply and scale steps on
// the 25x24 shared multiplier and the final sum; an output stall holds it in the sum state.
// Beats do not overlap: s_tready is high only while the sequencer is idle.
// Reset (arst_n low, asynchronous): integrator and previous error cleared, gains and offset
// return to their defaults, no output beat pending.
`timescale 1ns / 1ps
module line_position_pid (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// far_left, mid_left, near_left, near_right, mid_right, far_right (lowest bits first)
	input  logic [lpp_pkg::S_TDATA_W-1:0]       s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// drive_right, drive_left (lowest bits first)
	output logic [lpp_pkg::M_TDATA_W-1:0]       m_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lpp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [lpp_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import lpp_pkg::*;

	state_t state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;

	logic signed [OFFSET_W-1:0] offset_q;
	logic [GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q;

	logic signed [ERR_W-1:0]  err_q, prev_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic signed [OUT_W-1:0]  integ_q, p_q, i_q, d_q;
	logic [PROD_W-1:0] prod_q, hi_q;
	logic m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	// error from the sensor beat
	logic [SENSOR_BITS-1:0] fl, ml, nl, nr, mr, fr;
	logic signed [CALC_W-1:0] left_w, right_w, err_w;
	logic signed [ERR_W-1:0] err_sat;

	assign fl = s_tdata[0*SENSOR_BITS +: SENSOR_BITS];
	assign ml = s_tdata[1*SENSOR_BITS +: SENSOR_BITS];
	assign nl = s_tdata[2*SENSOR_BITS +: SENSOR_BITS];
	assign nr = s_tdata[3*SENSOR_BITS +: SENSOR_BITS];
	assign mr = s_tdata[4*SENSOR_BITS +: SENSOR_BITS];
	assign fr = s_tdata[5*SENSOR_BITS +: SENSOR_BITS];

	always_comb begin
		left_w = CALC_W'(W_FAR) * signed'(CALC_W'(fl))
			+ CALC_W'(W_MID) * signed'(CALC_W'(ml))
			+ CALC_W'(W_NEAR) * signed'(CALC_W'(nl))
			+ CALC_W'(W_NEAR) * CALC_W'(offset_q);
		right_w = CALC_W'(W_NEAR) * signed'(CALC_W'(nr))
			+ CALC_W'(W_MID) * signed'(CALC_W'(mr))
			+ CALC_W'(W_FAR) * signed'(CALC_W'(fr));
		err_w = left_w - right_w;
		if (err_w > CALC_W'(ERR_MAX))
			err_sat = ERR_MAX;
		else if (err_w < CALC_W'(ERR_MIN))
			err_sat = ERR_MIN;
		else
			err_sat = err_w[ERR_W-1:0];
	end

	// shared multiplier operand select
	logic op_diff, op_lo, op_neg;
	logic [1:0] op_gain;
	logic [MAG_W-1:0] err_mag, diff_mag, mul_a;
	logic [GAIN_W-1:0] gain_sel;
	logic [GAIN_HI_W-1:0] mul_b;

	assign err_mag  = err_q[ERR_W-1] ? MAG_W'(-DIFF_W'(err_q)) : MAG_W'(DIFF_W'(err_q));
	assign diff_mag = diff_q[DIFF_W-1] ? MAG_W'(-diff_q) : MAG_W'(diff_q);

	always_comb begin
		op_gain = step_q[2:1];
		op_lo   = step_q[0];
		op_diff = step_q[2];
		mul_a   = op_diff ? diff_mag : err_mag;
		case (op_gain)
			2'd0:    gain_sel = gain_p_q;
			2'd1:    gain_sel = gain_i_q;
			default: gain_sel = gain_d_q;
		endcase
		mul_b = op_lo ? GAIN_HI_W'(gain_sel[GAIN_LO_W-1:0]) : gain_sel[GAIN_W-1:GAIN_LO_W];
	end

	// scaling of the product finished in the previous step
	logic [STEP_W-1:0] prev_step;
	logic [FULL_W-1:0] full_w, shifted_w;
	logic signed [OUT_W-1:0] scaled;

	assign prev_step = step_q - STEP_W'(1);
	assign op_neg = prev_step[2] ? diff_q[DIFF_W-1] : err_q[ERR_W-1];

	always_comb begin
		full_w = {1'b0, hi_q, {GAIN_LO_W{1'b0}}} + FULL_W'(prod_q);
		shifted_w = full_w >> SCALE_SH;
		if (|shifted_w[FULL_W-1:OUT_W-1])
			scaled = op_neg ? OUT_MIN : OUT_MAX;
		else if (op_neg)
			scaled = -signed'(shifted_w[OUT_W-1:0]);
		else
			scaled = signed'(shifted_w[OUT_W-1:0]);
	end

	// integrator and final sum
	logic signed [OUT_W:0] integ_w;
	logic signed [SUM_W-1:0] sum_w;
	logic signed [OUT_W-1:0] integ_sat, right_sat, left_out;

	always_comb begin
		integ_w = (OUT_W+1)'(integ_q) + (OUT_W+1)'(i_q);
		if (integ_w > (OUT_W+1)'(OUT_MAX))
			integ_sat = OUT_MAX;
		else if (integ_w < (OUT_W+1)'(OUT_MIN))
			integ_sat = OUT_MIN;
		else
			integ_sat = integ_w[OUT_W-1:0];
		sum_w = SUM_W'(p_q) + SUM_W'(integ_q) + SUM_W'(d_q);
		if (sum_w > SUM_W'(OUT_MAX))
			right_sat = OUT_MAX;
		else if (sum_w < SUM_W'(OUT_MIN))
			right_sat = OUT_MIN;
		else
			right_sat = sum_w[OUT_W-1:0];
		left_out = (right_sat == OUT_MIN) ? OUT_MAX : -right_sat;
	end

	// sequencer
	logic out_free;
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = ST_CALC;
					step_d  = '0;
				end
			end
			ST_CALC: begin
				step_d = step_q + STEP_W'(1);
				if (step_q == STEP_LAST)
					state_d = ST_SUM;
			end
			ST_SUM: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			gain_p_q <= GAIN_P_RST;
			gain_i_q <= GAIN_I_RST;
			gain_d_q <= GAIN_D_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LINE_OFFSET: offset_q <= cfg_data[OFFSET_W-1:0];
				REG_GAIN_P:      gain_p_q <= cfg_data;
				REG_GAIN_I_DT:   gain_i_q <= cfg_data;
				REG_GAIN_D_DT:   gain_d_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			integ_q <= '0;
		end else if (state_q == ST_CALC) begin
			if (step_q == '0)
				prev_q <= err_q;
			if (step_q == STEP_INTEG)
				integ_q <= integ_sat;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid)
			err_q <= err_sat;
		if (state_q == ST_CALC) begin
			prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
			if (step_q == '0)
				diff_q <= DIFF_W'(err_q) - DIFF_W'(prev_q);
			if (step_q != '0) begin
				if (!prev_step[0]) begin
					hi_q <= prod_q;
				end else begin
					case (prev_step[2:1])
						2'd0:    p_q <= scaled;
						2'd1:    i_q <= scaled;
						default: d_q <= scaled;
					endcase
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (state_q == ST_SUM && out_free)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SUM && out_free)
			m_tdata_q <= {left_out, right_sat};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// checks
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == ST_CALC && step_q == '0)
		else $error("accepted beat did not start the sequencer");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CALC |-> step_q <= STEP_LAST)
		else $error("step counter out of range");

	a_left_is_neg: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[M_TDATA_W-1:OUT_W] ==
			((m_tdata[OUT_W-1:0] == OUT_MIN) ? OUT_MAX : -m_tdata[OUT_W-1:0])))
		else $error("left drive is not the negated right drive");

	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready && state_q == ST_SUM |=> state_q == ST_SUM)
		else $error("result left the sum state while output was stalled");

endmodule
